[rtl/mtbr_pkg.sv]
// Shared types, constants and decode functions for the meta text block reassembler.
// Used by every module under rtl; depends on nothing else.
package mtbr_pkg;

	localparam int DEF_BLOCK_BYTES = 13;
	localparam int DEF_MAX_BLOCKS  = 4;
	localparam int IN_BYTES        = 13;
	localparam int IN_BITS         = 8 * IN_BYTES;
	localparam int TEXT_CAP        = 52;

	localparam logic [7:0] CTRL_CLEAR = 8'h00;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic [3:0] LEN_ONE   = 4'h1;
	localparam logic [3:0] LEN_TWO   = 4'h3;
	localparam logic [3:0] LEN_THREE = 4'h7;
	localparam logic [3:0] LEN_FOUR  = 4'hF;
	localparam logic [3:0] IDX_ZERO  = 4'h1;
	localparam logic [3:0] IDX_ONE   = 4'h2;
	localparam logic [3:0] IDX_TWO   = 4'h4;
	localparam logic [3:0] IDX_THREE = 4'h8;

	typedef enum logic [1:0] {
		ST_INCOMPLETE = 2'd0,
		ST_CHAR       = 2'd1,
		ST_REJECT     = 2'd2,
		ST_CLEARED    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WRITE,
		S_CHECK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FINISH,
		S_EMIT_RD,
		S_EMIT_WR,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic clear;
	} mtbr_mem_ctl_t;

	typedef struct packed {
		logic        load;
		status_t     status;
		logic [7:0]  text_char;
		logic [5:0]  char_position;
		logic [5:0]  text_length;
		logic        last;
	} mtbr_load_t;

	// Block count from the thermometer code; zero means the code is invalid.
	function automatic logic [2:0] count_of_code(input logic [3:0] code);
		logic [2:0] cnt;
		case (code)
			LEN_ONE:   cnt = 3'd1;
			LEN_TWO:   cnt = 3'd2;
			LEN_THREE: cnt = 3'd3;
			LEN_FOUR:  cnt = 3'd4;
			default:   cnt = 3'd0;
		endcase
		return cnt;
	endfunction

	// Block index from the one-hot code; the top bit flags an invalid code.
	function automatic logic [2:0] index_of_code(input logic [3:0] code);
		logic [2:0] idx;
		case (code)
			IDX_ZERO:  idx = 3'd0;
			IDX_ONE:   idx = 3'd1;
			IDX_TWO:   idx = 3'd2;
			IDX_THREE: idx = 3'd3;
			default:   idx = 3'b100;
		endcase
		return idx;
	endfunction

endpackage

[rtl/mtbr_store.sv]
// Text store of the reassembler: a single-write, single-read byte memory with a
// per-entry valid bit, so a clear resets every entry at once. Depends on mtbr_pkg.
module mtbr_store #(
	parameter int BLOCK_BYTES = 13,
	parameter int MAX_BLOCKS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mtbr_pkg::mtbr_mem_ctl_t mem_ctl,
	input  logic [((MAX_BLOCKS*BLOCK_BYTES > 1) ? $clog2(MAX_BLOCKS*BLOCK_BYTES) : 1)-1:0] wr_addr,
	input  logic [7:0]             wr_data,
	input  logic [((MAX_BLOCKS*BLOCK_BYTES > 1) ? $clog2(MAX_BLOCKS*BLOCK_BYTES) : 1)-1:0] rd_addr,
	output logic [7:0]             rd_byte
);
	import mtbr_pkg::*;

	localparam int STORE_DEPTH = MAX_BLOCKS * BLOCK_BYTES;

	logic [7:0]             mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [7:0]             rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (mem_ctl.clear) begin
				valid_q <= '0;
			end else if (mem_ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (mem_ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_byte = rd_valid_q ? rd_data_q : 8'h00;

endmodule

[rtl/mtbr_out.sv]
// Result register of the reassembler: holds one result until the transfer completes.
// Depends on mtbr_pkg.
module mtbr_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mtbr_pkg::mtbr_load_t load,
	output logic                 out_free,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [1:0]           status,
	output logic [7:0]           text_char,
	output logic [5:0]           char_position,
	output logic [5:0]           text_length,
	output logic                 last
);
	import mtbr_pkg::*;

	logic       valid_q;
	logic [1:0] status_q;
	logic [7:0] char_q;
	logic [5:0] pos_q;
	logic [5:0] len_q;
	logic       last_q;

	assign out_free = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load.load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load.load) begin
			status_q <= load.status;
			char_q   <= load.text_char;
			pos_q    <= load.char_position;
			len_q    <= load.text_length;
			last_q   <= load.last;
		end
	end

	assign result_valid  = valid_q;
	assign status        = status_q;
	assign text_char     = char_q;
	assign char_position = pos_q;
	assign text_length   = len_q;
	assign last          = last_q;

endmodule

[rtl/mtbr_seq.sv]
// Sequencer of the reassembler: decodes a block, writes it byte by byte into the
// text store, scans off trailing spaces and emits the message. Depends on mtbr_pkg.
module mtbr_seq #(
	parameter int BLOCK_BYTES = 13,
	parameter int MAX_BLOCKS  = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  logic [7:0]              control_byte,
	input  logic [39:0]             text_head,
	input  logic [63:0]             text_tail,
	output mtbr_pkg::mtbr_mem_ctl_t mem_ctl,
	output logic [((MAX_BLOCKS*BLOCK_BYTES > 1) ? $clog2(MAX_BLOCKS*BLOCK_BYTES) : 1)-1:0] wr_addr,
	output logic [7:0]              wr_data,
	output logic [((MAX_BLOCKS*BLOCK_BYTES > 1) ? $clog2(MAX_BLOCKS*BLOCK_BYTES) : 1)-1:0] rd_addr,
	input  logic [7:0]              rd_byte,
	input  logic                    out_free,
	output mtbr_pkg::mtbr_load_t    load
);
	import mtbr_pkg::*;

	localparam int STORE_DEPTH = MAX_BLOCKS * BLOCK_BYTES;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
	localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);

	seq_state_t           state_q, state_d;
	logic [7:0]           ctrl_q;
	logic [IN_BITS-1:0]   shift_q;
	logic [3:0]           exp_q;
	logic [3:0]           recv_q;
	logic [ADDR_W-1:0]    base_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     pos_q;
	status_t              resp_q;

	logic [3:0]           len_code;
	logic [3:0]           blk_code;
	logic [2:0]           total;
	logic [2:0]           idx_code;
	logic                 is_clear;
	logic                 block_ok;
	logic                 count_change;
	logic                 write_done;
	logic                 is_space;
	logic                 emit_last;
	logic [LEN_W-1:0]     len_m1;

	always_comb begin
		len_code     = ctrl_q[7:4];
		blk_code     = ctrl_q[3:0];
		total        = count_of_code(len_code);
		idx_code     = index_of_code(blk_code);
		is_clear     = (ctrl_q == CTRL_CLEAR);
		block_ok     = (total != 3'd0) && !idx_code[2] && ({1'b0, idx_code[1:0]} < total)
			&& (int'(total) <= MAX_BLOCKS);
		count_change = (exp_q != 4'h0) && (exp_q != len_code);
		write_done   = (cnt_q == CNT_W'(BLOCK_BYTES - 1));
		is_space     = (rd_byte == SPACE_CHAR);
		len_m1       = len_q - LEN_W'(1);
		emit_last    = (pos_q == len_m1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_clear || !block_ok) begin
					state_d = S_RESP;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (write_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (recv_q != exp_q) begin
					state_d = S_RESP;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (len_q == '0) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (is_space) begin
					state_d = S_SCAN_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (len_q == '0) begin
					state_d = S_RESP;
				end else begin
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_WR;
			end
			S_EMIT_WR: begin
				if (out_free) begin
					state_d = emit_last ? S_IDLE : S_EMIT_RD;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready         = 1'b0;
		mem_ctl            = '0;
		wr_addr            = ADDR_W'(base_q + ADDR_W'(cnt_q));
		wr_data            = shift_q[IN_BITS-1 -: 8];
		rd_addr            = pos_q[ADDR_W-1:0];
		load               = '0;
		load.status        = resp_q;
		load.last          = 1'b1;
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
			end
			S_DECODE: begin
				mem_ctl.clear = is_clear || (block_ok && count_change);
			end
			S_WRITE: begin
				mem_ctl.wr_en = 1'b1;
			end
			S_SCAN_RD: begin
				mem_ctl.rd_en = (len_q != '0);
				rd_addr       = len_m1[ADDR_W-1:0];
			end
			S_EMIT_RD: begin
				mem_ctl.rd_en = 1'b1;
			end
			S_EMIT_WR: begin
				load.load          = out_free;
				load.status        = ST_CHAR;
				load.text_char     = rd_byte;
				load.char_position = 6'(pos_q);
				load.text_length   = 6'(len_q);
				load.last          = emit_last;
			end
			S_RESP: begin
				load.load = out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			exp_q   <= 4'h0;
			recv_q  <= 4'h0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DECODE) begin
				if (is_clear) begin
					exp_q  <= 4'h0;
					recv_q <= 4'h0;
				end else if (block_ok) begin
					exp_q  <= len_code;
					recv_q <= count_change ? blk_code : (recv_q | blk_code);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ctrl_q  <= control_byte;
				shift_q <= {text_head, text_tail};
			end
			S_DECODE: begin
				resp_q <= is_clear ? ST_CLEARED : ST_REJECT;
				base_q <= ADDR_W'(int'(idx_code[1:0]) * BLOCK_BYTES);
				len_q  <= LEN_W'(int'(total) * BLOCK_BYTES);
				cnt_q  <= '0;
			end
			S_WRITE: begin
				shift_q <= shift_q << 8;
				cnt_q   <= cnt_q + CNT_W'(1);
			end
			S_CHECK: begin
				resp_q <= ST_INCOMPLETE;
			end
			S_SCAN_CHK: begin
				if (is_space) begin
					len_q <= len_m1;
				end
			end
			S_FINISH: begin
				if (int'(len_q) > TEXT_CAP) begin
					len_q <= LEN_W'(TEXT_CAP);
				end
				pos_q  <= '0;
				resp_q <= ST_CHAR;
			end
			S_EMIT_WR: begin
				if (out_free) begin
					pos_q <= pos_q + LEN_W'(1);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule

[rtl/meta_text_block_reassembler_top.sv]
// For an item that completes a message, the sequencer takes the block in on the transfer and
// then decodes it. It writes the block's BLOCK_BYTES text bytes into the text store, one per
// cycle, and checks the block map. After that it walks back over the trailing spaces, reading
// and testing one byte at a time, until a byte that is not a space or an empty text ends the
// scan. It then sets up the output, and each character is read through the store's registered
// read port before it goes to the result register. A rejected or cleared block goes from
// decoding straight to its single result; an incomplete block is first written and checked.
// The sequencer waits whenever the result register still holds a result awaiting a transfer.
// The input is not ready until every result of the current block has been handed to the result
// register; that register lets the next block start while the last result waits for a transfer.
// Clearing the store is done at once through per-entry valid bits, so there is no clearing pass.
// Top level of the meta text block reassembler; depends on mtbr_pkg, mtbr_seq, mtbr_store and
// mtbr_out.
module meta_text_block_reassembler_top #(
	parameter int BLOCK_BYTES = mtbr_pkg::DEF_BLOCK_BYTES,
	parameter int MAX_BLOCKS  = mtbr_pkg::DEF_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [7:0]  control_byte,
	input  logic [39:0] text_head,
	input  logic [63:0] text_tail,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  status,
	output logic [7:0]  text_char,
	output logic [5:0]  char_position,
	output logic [5:0]  text_length,
	output logic        last
);
	import mtbr_pkg::*;

	localparam int STORE_DEPTH = MAX_BLOCKS * BLOCK_BYTES;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	mtbr_mem_ctl_t     mem_ctl;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_byte;
	logic              out_free;
	mtbr_load_t        load;

	mtbr_seq #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.control_byte(control_byte),
		.text_head   (text_head),
		.text_tail   (text_tail),
		.mem_ctl     (mem_ctl),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_byte     (rd_byte),
		.out_free    (out_free),
		.load        (load)
	);

	mtbr_store #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.mem_ctl(mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_byte(rd_byte)
	);

	mtbr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.text_char    (text_char),
		.char_position(char_position),
		.text_length  (text_length),
		.last         (last)
	);

endmodule

[rtl/mtbr_checker.sv]
// Port-level checker for the meta text block reassembler, bound to the top level.
// Depends on mtbr_pkg and meta_text_block_reassembler_top.
module mtbr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  status,
	input logic [7:0]  text_char,
	input logic [5:0]  char_position,
	input logic [5:0]  text_length,
	input logic        last
);
	import mtbr_pkg::*;

	// A block is worked on alone, so the input closes right after a transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input ready right after a transfer");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(status) && $stable(text_char)
			&& $stable(char_position) && $stable(last))
		else $error("stalled result changed");

	a_position_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_CHAR) && (text_length != 6'd0)
			|-> (char_position < text_length) && (text_length <= 6'(TEXT_CAP)))
		else $error("character position outside the message");

	a_last_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_CHAR) && (text_length != 6'd0)
			|-> (last == (char_position + 6'd1 == text_length)))
		else $error("last flag does not match the final character");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ((status != ST_CHAR) || (text_length == 6'd0))
			|-> last && (text_char == 8'h00) && (char_position == 6'd0))
		else $error("single result carries character data");

endmodule

bind meta_text_block_reassembler_top mtbr_checker u_mtbr_checker (.*);

[test/tb.sv]
// Self-checking testbench for meta_text_block_reassembler_top: directed and random text blocks
// are checked against a built-in reassembly predictor, with random idling on both channels.
// Depends on mtbr_pkg and the RTL under rtl.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mtbr_pkg::*;

	localparam int BLK          = DEF_BLOCK_BYTES;
	localparam int STORE_BYTES  = DEF_BLOCK_BYTES * DEF_MAX_BLOCKS;
	localparam int RANDOM_ITEMS = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		status_t    status;
		logic [7:0] ch;
		logic [5:0] pos;
		logic [5:0] len;
		logic       last;
	} text_result_t;

	typedef enum int {TXT_RANDOM, TXT_PADDED, TXT_SPACES, TXT_FULL} text_kind_t;

	class reassembly_tracker;
		text_result_t awaited[$];
		logic [7:0]   text_store[STORE_BYTES];
		logic [3:0]   count_code;
		logic [3:0]   seen_blocks;
		logic [7:0]   code_history;
		int           errors, blocks, messages, chars, rejects, clears;

		function new();
			wipe();
			errors = 0;
			blocks = 0;
			messages = 0;
			chars = 0;
			rejects = 0;
			clears = 0;
		endfunction

		function void wipe();
			foreach (text_store[i]) text_store[i] = 8'h00;
			count_code = 4'h0;
			seen_blocks = 4'h0;
			code_history = 8'h00;
		endfunction

		function void expect_one(status_t st);
			text_result_t r;
			r.status = st;
			r.ch = 8'h00;
			r.pos = 6'd0;
			r.len = 6'd0;
			r.last = 1'b1;
			awaited.push_back(r);
		endfunction

		function int block_count(logic [3:0] code);
			case (code)
				LEN_ONE:   return 1;
				LEN_TWO:   return 2;
				LEN_THREE: return 3;
				LEN_FOUR:  return 4;
				default:   return 0;
			endcase
		endfunction

		function int slot_of_code(logic [3:0] code);
			case (code)
				IDX_ZERO:  return 0;
				IDX_ONE:   return 1;
				IDX_TWO:   return 2;
				IDX_THREE: return 3;
				default:   return -1;
			endcase
		endfunction

		function void reassemble_block(logic [7:0] ctrl, logic [39:0] head, logic [63:0] tail);
			logic [3:0]   len_code, blk_code;
			logic [7:0]   b;
			int           total, idx, base, n;
			text_result_t r;
			blocks++;
			if (ctrl == CTRL_CLEAR) begin
				wipe();
				clears++;
				expect_one(ST_CLEARED);
				return;
			end
			len_code = ctrl[7:4];
			blk_code = ctrl[3:0];
			total = block_count(len_code);
			idx = slot_of_code(blk_code);
			if (total == 0 || idx < 0 || idx >= total || total > DEF_MAX_BLOCKS) begin
				rejects++;
				expect_one(ST_REJECT);
				return;
			end
			if (count_code != 4'h0 && count_code != len_code)
				wipe();
			count_code = len_code;
			seen_blocks = seen_blocks | blk_code;
			code_history = code_history | {len_code, blk_code};
			base = idx * BLK;
			for (int i = 0; i < BLK; i++) begin
				if (i >= IN_BYTES)
					b = 8'h00;
				else if (i < 5)
					b = head[8 * (4 - i) +: 8];
				else
					b = tail[8 * (12 - i) +: 8];
				if (base + i < STORE_BYTES)
					text_store[base + i] = b;
			end
			if (code_history[7:4] != code_history[3:0] || seen_blocks != count_code) begin
				expect_one(ST_INCOMPLETE);
				return;
			end
			messages++;
			n = total * BLK;
			if (n > STORE_BYTES)
				n = STORE_BYTES;
			while (n > 0 && text_store[n - 1] == SPACE_CHAR)
				n--;
			if (n > TEXT_CAP)
				n = TEXT_CAP;
			if (n == 0) begin
				expect_one(ST_CHAR);
				return;
			end
			for (int i = 0; i < n; i++) begin
				r.status = ST_CHAR;
				r.ch = text_store[i];
				r.pos = 6'(i);
				r.len = 6'(n);
				r.last = (i == n - 1);
				awaited.push_back(r);
			end
			chars += n;
		endfunction

		function void check_result(logic [1:0] st, logic [7:0] ch, logic [5:0] pos,
				logic [5:0] len, logic lst);
			text_result_t e;
			if (awaited.size() == 0) begin
				$error("status: no result awaited, got %0d", st);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (ch !== e.ch) begin
				$error("text_char: expected %0h, got %0h", e.ch, ch);
				errors++;
			end
			if (pos !== e.pos) begin
				$error("char_position: expected %0d, got %0d", e.pos, pos);
				errors++;
			end
			if (len !== e.len) begin
				$error("text_length: expected %0d, got %0d", e.len, len);
				errors++;
			end
			if (lst !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, lst);
				errors++;
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [7:0]  control_byte = 8'h00;
	logic [39:0] text_head = 40'h0;
	logic [63:0] text_tail = 64'h0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  status;
	logic [7:0]  text_char;
	logic [5:0]  char_position;
	logic [5:0]  text_length;
	logic        last;

	reassembly_tracker tracker;
	int send_gap_max = 8;
	int stall_max = 8;
	bit hold_request = 1'b0;
	int items_sent = 0;

	meta_text_block_reassembler_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.control_byte(control_byte),
		.text_head(text_head),
		.text_tail(text_tail),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.text_char(text_char),
		.char_position(char_position),
		.text_length(text_length),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] block_ctrl(int count, int index);
		logic [3:0] lc, ic;
		case (count)
			1:       lc = LEN_ONE;
			2:       lc = LEN_TWO;
			3:       lc = LEN_THREE;
			default: lc = LEN_FOUR;
		endcase
		case (index)
			0:       ic = IDX_ZERO;
			1:       ic = IDX_ONE;
			2:       ic = IDX_TWO;
			default: ic = IDX_THREE;
		endcase
		return {lc, ic};
	endfunction

	function automatic void pack_block(input logic [7:0] b[IN_BYTES], output logic [39:0] head,
			output logic [63:0] tail);
		head = 40'h0;
		tail = 64'h0;
		for (int i = 0; i < 5; i++)
			head = {head[31:0], b[i]};
		for (int i = 5; i < IN_BYTES; i++)
			tail = {tail[55:0], b[i]};
	endfunction

	function automatic void text_of(input string s, output logic [39:0] head,
			output logic [63:0] tail);
		logic [7:0] b[IN_BYTES];
		for (int i = 0; i < IN_BYTES; i++)
			b[i] = (i < s.len()) ? s[i] : SPACE_CHAR;
		pack_block(b, head, tail);
	endfunction

	function automatic void gen_text(input text_kind_t kind, output logic [39:0] head,
			output logic [63:0] tail);
		logic [7:0] b[IN_BYTES];
		int keep;
		keep = $urandom_range(0, IN_BYTES - 1);
		for (int i = 0; i < IN_BYTES; i++) begin
			case (kind)
				TXT_RANDOM: b[i] = 8'($urandom);
				TXT_SPACES: b[i] = SPACE_CHAR;
				TXT_FULL:   b[i] = 8'($urandom_range(33, 126));
				default: begin
					if (i >= keep || $urandom_range(0, 7) == 0)
						b[i] = SPACE_CHAR;
					else
						b[i] = 8'($urandom_range(33, 126));
				end
			endcase
		end
		pack_block(b, head, tail);
	endfunction

	function automatic text_kind_t pick_kind(bit final_block);
		int r;
		r = $urandom_range(0, 99);
		if (final_block) begin
			if (r < 50) return TXT_PADDED;
			if (r < 65) return TXT_SPACES;
			if (r < 80) return TXT_RANDOM;
			return TXT_FULL;
		end
		if (r < 30) return TXT_RANDOM;
		if (r < 40) return TXT_SPACES;
		return TXT_PADDED;
	endfunction

	task automatic send_block(input logic [7:0] ctrl, input logic [39:0] head,
			input logic [63:0] tail);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		control_byte <= ctrl;
		text_head <= head;
		text_tail <= tail;
		do @(posedge clk); while (item_ready !== 1'b1);
		tracker.reassemble_block(ctrl, head, tail);
		items_sent++;
	endtask

	task automatic send_text(input logic [7:0] ctrl, input string s);
		logic [39:0] h;
		logic [63:0] t;
		text_of(s, h, t);
		send_block(ctrl, h, t);
	endtask

	task automatic send_long_message();
		logic [39:0] h;
		logic [63:0] t;
		for (int k = 0; k < 4; k++) begin
			gen_text(TXT_FULL, h, t);
			send_block(block_ctrl(4, k), h, t);
		end
	endtask

	task automatic send_message(input int n, input bit partial);
		int order[4];
		int cnt, j, tmp;
		logic [39:0] h;
		logic [63:0] t;
		for (int k = 0; k < n; k++)
			order[k] = k;
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		cnt = (partial && n > 1) ? $urandom_range(1, n - 1) : n;
		for (int k = 0; k < cnt; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				gen_text(TXT_RANDOM, h, t);
				send_block(block_ctrl(n, order[k]), h, t);
			end
			gen_text(pick_kind(order[k] == n - 1), h, t);
			send_block(block_ctrl(n, order[k]), h, t);
		end
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				result_ready <= 1'b1;
			end else begin
				stall = $urandom_range(0, stall_max);
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				result_ready <= 1'b1;
			end
			do @(posedge clk); while (!(result_valid === 1'b1 && result_ready === 1'b1));
			tracker.check_result(status, text_char, char_position, text_length, last);
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int target, r;
		bit hold_done;
		logic [39:0] h;
		logic [63:0] t;
		tracker = new();
		hold_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_block(CTRL_CLEAR, 40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_text(block_ctrl(1, 0), "HELLO");
		send_text(block_ctrl(1, 0), "");
		send_block(block_ctrl(1, 0), 40'h0, 64'h0);
		send_block(block_ctrl(1, 0), 40'hFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_text({4'h2, IDX_ZERO}, "BAD");
		send_text({LEN_ONE, 4'h3}, "BAD");
		send_text({LEN_ONE, IDX_ONE}, "BAD");
		send_text({LEN_ONE, 4'h0}, "BAD");
		send_text({4'h0, IDX_ZERO}, "BAD");
		send_text(8'hFF, "BAD");
		send_text(block_ctrl(2, 1), "WORLD");
		send_text(block_ctrl(2, 0), "HI");
		send_text(block_ctrl(3, 0), "A");
		send_text(block_ctrl(4, 1), "B");
		send_text(block_ctrl(4, 0), "C");
		send_text(block_ctrl(4, 3), "");
		send_text(block_ctrl(4, 2), "");
		send_text(block_ctrl(3, 1), "X");
		send_text(block_ctrl(3, 1), "Y");
		gen_text(TXT_RANDOM, h, t);
		send_block(block_ctrl(3, 0), h, t);
		send_text(block_ctrl(3, 2), "ZZZZZZZZZZZZZ");
		send_block(CTRL_CLEAR, 40'h0, 64'h0);
		send_long_message();

		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: begin send_gap_max = 0; stall_max = 0; end
					1: begin send_gap_max = 8; stall_max = 8; end
					2: begin send_gap_max = 0; stall_max = 8; end
					default: begin send_gap_max = 8; stall_max = 0; end
				endcase
			end
			if (!hold_done && items_sent >= target - RANDOM_ITEMS / 2) begin
				hold_done = 1'b1;
				send_gap_max = 0;
				hold_request = 1'b1;
				send_long_message();
				send_long_message();
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_message($urandom_range(1, 4), 1'b0);
			end else if (r < 85) begin
				gen_text(TXT_RANDOM, h, t);
				send_block(8'($urandom), h, t);
			end else if (r < 90) begin
				gen_text(TXT_RANDOM, h, t);
				send_block(CTRL_CLEAR, h, t);
			end else begin
				send_message($urandom_range(2, 4), 1'b1);
			end
		end
		item_valid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d blocks: %0d messages completed, %0d characters, %0d rejected, %0d clears.",
			tracker.blocks, tracker.messages, tracker.chars, tracker.rejects, tracker.clears);
		if (tracker.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
